// ===== rtl/bsc_pkg.sv =====
package bsc_pkg;

  localparam int MaxProcs  = 16;
  localparam int MaxRes    = 8;
  localparam int ValueBits = 16;
  localparam int ProcBits  = 4;
  localparam int ResBits   = 3;
  localparam int WorkBits  = 21;
  localparam int NeedBits  = ValueBits + 1;
  localparam int NpBits    = 5;
  localparam int NrBits    = 4;
  localparam int MemDepth  = MaxProcs * MaxRes;
  localparam int AddrBits  = ProcBits + ResBits;

  localparam logic [1:0] REQ_AVAIL = 2'd0;
  localparam logic [1:0] REQ_MAX   = 2'd1;
  localparam logic [1:0] REQ_ALLOC = 2'd2;
  localparam logic [1:0] REQ_CHECK = 2'd3;

  localparam logic [0:0] CFG_NUM_PROCS = 1'd0;
  localparam logic [0:0] CFG_NUM_RES   = 1'd1;

  // Controller to datapath commands.
  typedef struct packed {
    logic                init;      // load work vector from available, clear flags
    logic                rd;        // issue matrix read at proc/res
    logic [ProcBits-1:0] proc;
    logic [ResBits-1:0]  res;
    logic                cmp;       // compare registered read data against work
    logic                add;       // add registered alloc into work[res]
    logic                grant;     // mark proc finished and append to sequence
    logic                seq_rd;    // read sequence entry at seq_idx
    logic [ProcBits-1:0] seq_idx;
  } cmd_t;

  typedef struct packed {
    logic                fits;      // need <= work on compared column
    logic                finished;  // finished flag of cmd.proc
    logic [ProcBits-1:0] seq_proc;
  } stat_t;

endpackage

// ===== rtl/bankers_safety_check_unit.sv =====
// Banker's safety check unit.
// Input channel (in_valid/in_stall): req_type, proc_index, res_index, value.
// Load items (available, max claim, allocation) are taken one per cycle
// while no check runs and give no result. A check item runs the safety test
// over the loaded stores and holds in_stall high until its last result sits
// in the output register. Output channel (out_valid/out_stall): is_safe,
// proc_id, last. A safe system yields one transaction per process (num_procs
// after clamping) in safe order, last marking the final one; an unsafe system
// yields one transaction with is_safe 0, proc_id 0. A check walks the
// matrices one entry at a time through a single memory read port: each process
// visit compares its row resource by resource, and each grant walks its alloc
// row again to add it into work, for up to num_procs passes.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes num_procs
// and num_resources; out-of-range values are clamped where a check uses them.
// Reset (rst, synchronous) drops any check in flight, empties the output
// register and sets both counts to 1; the stores keep stale contents.
// When the receiver stalls, hold the current result and pause the check.
module bankers_safety_check_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    req_type,
  input  logic [bsc_pkg::ProcBits-1:0]  proc_index,
  input  logic [bsc_pkg::ResBits-1:0]   res_index,
  input  logic [bsc_pkg::ValueBits-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          is_safe,
  output logic [bsc_pkg::ProcBits-1:0]  proc_id,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [bsc_pkg::NpBits-1:0]    cfg_data
);
  import bsc_pkg::*;

  logic [NpBits-1:0] num_procs;
  logic [NrBits-1:0] num_resources;
  logic [NpBits-1:0] np;
  logic [NrBits-1:0] nr;
  logic              busy, accept, start, load_en;
  cmd_t              cmd;
  stat_t             stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_procs     <= NpBits'(1);
      num_resources <= NrBits'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_PROCS: num_procs     <= cfg_data;
        CFG_NUM_RES:   num_resources <= cfg_data[NrBits-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to the stores.
  assign np = (num_procs == '0) ? NpBits'(1)
            : (num_procs > NpBits'(MaxProcs)) ? NpBits'(MaxProcs) : num_procs;
  assign nr = (num_resources == '0) ? NrBits'(1)
            : (num_resources > NrBits'(MaxRes)) ? NrBits'(MaxRes) : num_resources;

  // Hold the input channel while a check runs.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;
  assign start    = accept && req_type == REQ_CHECK;
  assign load_en  = accept && req_type != REQ_CHECK;

  bsc_ctrl u_ctrl (
    .clk, .rst, .start, .np, .nr, .stat, .cmd,
    .busy,
    .res_valid (out_valid),
    .res_stall (out_stall),
    .res_safe  (is_safe),
    .res_proc  (proc_id),
    .res_last  (last)
  );

  bsc_datapath u_dp (
    .clk, .rst, .load_en, .req_type, .proc_index, .res_index, .value,
    .nr, .cmd, .stat
  );

endmodule

// ===== rtl/bsc_datapath.sv =====
module bsc_datapath (
  input  logic                        clk,
  input  logic                        load_en,
  input  logic [1:0]                  req_type,
  input  logic [bsc_pkg::ProcBits-1:0] proc_index,
  input  logic [bsc_pkg::ResBits-1:0]  res_index,
  input  logic [bsc_pkg::ValueBits-1:0] value,
  input  logic [bsc_pkg::NrBits-1:0]  nr,
  input  logic                        rst,
  input  bsc_pkg::cmd_t               cmd,
  output bsc_pkg::stat_t              stat
);
  import bsc_pkg::*;

  logic [ValueBits-1:0] avail_mem [MaxRes];
  logic [ValueBits-1:0] max_mem   [MemDepth];
  logic [ValueBits-1:0] alloc_mem [MemDepth];
  logic [ProcBits-1:0]  seq_mem   [MaxProcs];
  logic [WorkBits-1:0]  work      [MaxRes];
  logic [MaxProcs-1:0]  finished;
  logic [ProcBits-1:0]  grant_cnt;
  logic [ValueBits-1:0] max_q, alloc_q;
  logic [ResBits-1:0]   res_q;
  logic [ProcBits-1:0]  seq_q;
  logic [AddrBits-1:0]  load_addr, rd_addr;
  logic signed [NeedBits:0]   need;
  logic signed [WorkBits:0]   work_s;

  assign load_addr = {proc_index, res_index};
  assign rd_addr   = {cmd.proc, cmd.res};

  always_ff @(posedge clk) begin
    if (load_en && req_type == REQ_MAX) max_mem[load_addr] <= value;
    if (load_en && req_type == REQ_ALLOC) alloc_mem[load_addr] <= value;
    if (load_en && req_type == REQ_AVAIL) avail_mem[res_index] <= value;
    if (cmd.rd) begin
      max_q   <= max_mem[rd_addr];
      alloc_q <= alloc_mem[rd_addr];
      res_q   <= cmd.res;
    end
    if (cmd.grant) seq_mem[grant_cnt] <= cmd.proc;
    if (cmd.seq_rd) seq_q <= seq_mem[cmd.seq_idx];
  end

  // Work vector and flags: an add updates a single column; init reloads every column and clears the flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      finished  <= '0;
      grant_cnt <= '0;
      for (int j = 0; j < MaxRes; j++) work[j] <= '0;
    end else if (cmd.init) begin
      finished  <= '0;
      grant_cnt <= '0;
      for (int j = 0; j < MaxRes; j++) begin
        work[j] <= (ResBits'(j) < nr[ResBits-1:0] || nr[ResBits])
                   ? WorkBits'(avail_mem[j]) : '0;
      end
    end else begin
      if (cmd.add) work[res_q] <= work[res_q] + WorkBits'(alloc_q);
      if (cmd.grant) begin
        finished[cmd.proc] <= 1'b1;
        grant_cnt          <= grant_cnt + 1'b1;
      end
    end
  end

  assign need   = $signed({2'b00, max_q}) - $signed({2'b00, alloc_q});
  assign work_s = $signed({1'b0, work[res_q]});
  assign stat.fits     = !((WorkBits+1)'(need) > work_s);
  assign stat.finished = finished[cmd.proc];
  assign stat.seq_proc = seq_q;

endmodule

// ===== rtl/bsc_ctrl.sv =====
module bsc_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bsc_pkg::NpBits-1:0]   np,
  input  logic [bsc_pkg::NrBits-1:0]   nr,
  input  bsc_pkg::stat_t               stat,
  output bsc_pkg::cmd_t                cmd,
  output logic                         busy,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic                         res_safe,
  output logic [bsc_pkg::ProcBits-1:0] res_proc,
  output logic                         res_last
);
  import bsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_PROC, S_READ, S_CMP, S_ADD, S_EMIT, S_OUT
  } state_t;

  state_t              state;
  logic [ProcBits-1:0] proc;
  logic [ResBits-1:0]  res;
  logic [NpBits-1:0]   granted;
  logic                found;
  logic                fail;
  logic [NpBits-1:0]   emit_idx;
  logic                res_wait;

  logic proc_end, res_end, emit_end;
  assign proc_end = (NpBits'(proc) + 1'b1 == np);
  assign res_end  = (NrBits'(res) + 1'b1 == nr);
  assign emit_end = (emit_idx + 1'b1 == np);

  // The add step reads the alloc column while res_wait is low, registers it, and adds it once res_wait is set.
  always_comb begin
    cmd         = '0;
    cmd.proc    = proc;
    cmd.res     = res;
    cmd.seq_idx = emit_idx[ProcBits-1:0];
    cmd.init    = (state == S_INIT);
    cmd.rd      = (state == S_READ) || (state == S_ADD && !res_wait);
    cmd.cmp     = (state == S_CMP);
    cmd.add     = (state == S_ADD) && res_wait;
    cmd.grant   = (state == S_ADD) && res_wait && res_end;
    cmd.seq_rd  = (state == S_EMIT);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      proc      <= '0;
      res       <= '0;
      granted   <= '0;
      found     <= 1'b0;
      fail      <= 1'b0;
      emit_idx  <= '0;
      res_wait  <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_OUT) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_INIT;
        end
        S_INIT: begin
          proc    <= '0;
          res     <= '0;
          granted <= '0;
          found   <= 1'b0;
          state   <= S_PROC;
        end
        S_PROC: begin
          res <= '0;
          if (stat.finished) begin
            priority if (!proc_end) proc <= proc + 1'b1;
            else if (!found) begin
              fail <= 1'b1; state <= S_EMIT;
            end else begin
              proc <= '0; found <= 1'b0;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          priority if (!stat.fits) begin
            res <= '0;
            priority if (!proc_end) begin
              proc <= proc + 1'b1; state <= S_PROC;
            end else if (!found) begin
              fail <= 1'b1; state <= S_EMIT;
            end else begin
              proc <= '0; found <= 1'b0; state <= S_PROC;
            end
          end else if (!res_end) begin
            res <= res + 1'b1; state <= S_READ;
          end else begin
            res <= '0; state <= S_ADD;
          end
        end
        S_ADD: begin
          // Walk alloc row again, adding each column into work.
          if (res_wait) begin
            res_wait <= 1'b0;
            if (res_end) begin
              granted <= granted + 1'b1;
              res     <= '0;
              priority if (granted + 1'b1 == np) begin
                emit_idx <= '0; state <= S_EMIT;
              end else if (!proc_end) begin
                proc <= proc + 1'b1; found <= 1'b1; state <= S_PROC;
              end else begin
                proc <= '0; found <= 1'b0; state <= S_PROC;
              end
            end else begin
              res <= res + 1'b1;
            end
          end else begin
            res_wait <= 1'b1;
          end
        end
        S_EMIT: state <= S_OUT;
        S_OUT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            res_safe  <= !fail;
            res_proc  <= fail ? '0 : stat.seq_proc;
            res_last  <= fail || emit_end;
            if (fail || emit_end) begin
              fail <= 1'b0; emit_idx <= '0; state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1; state <= S_EMIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.grant |-> !stat.finished) else $error("grant of finished process");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && res_valid && res_stall) |=> state == S_OUT)
    else $error("result overwritten under stall");
  assert property (@(posedge clk) disable iff (rst)
    start |-> state == S_IDLE) else $error("check started while busy");

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  // One transaction on the input channel.
  typedef struct {
    logic [1:0]          kind;
    logic [ProcBits-1:0] pidx;
    logic [ResBits-1:0]  ridx;
    logic [ValueBits-1:0] val;
  } req_item_t;

  // One transaction on the output channel.
  typedef struct {
    logic                safe;
    logic [ProcBits-1:0] pid;
    logic                fin;
  } grant_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           req_type = REQ_AVAIL;
  logic [ProcBits-1:0]  proc_index = '0;
  logic [ResBits-1:0]   res_index = '0;
  logic [ValueBits-1:0] value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 is_safe;
  logic [ProcBits-1:0]  proc_id;
  logic                 last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = CFG_NUM_PROCS;
  logic [NpBits-1:0]    cfg_data = '0;

  bankers_safety_check_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .proc_index (proc_index),
    .res_index  (res_index),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_safe    (is_safe),
    .proc_id    (proc_id),
    .last       (last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus waiting to be driven, and grants the block still owes us.
  req_item_t pending_reqs[$];
  grant_t    owed_grants[$];

  // Predictor copy of the block's stores and count registers.
  logic [ValueBits-1:0] avail_mdl[MaxRes];
  logic [ValueBits-1:0] claim_mdl[MemDepth];
  logic [ValueBits-1:0] alloc_mdl[MemDepth];
  logic [NpBits-1:0]    procs_reg = 5'd1;
  logic [NpBits-1:0]    res_reg   = 5'd1;

  // Generator-side view: which entries have been loaded, and the counts in use.
  bit avail_loaded[MaxRes];
  bit claim_loaded[MemDepth];
  bit alloc_loaded[MemDepth];
  int gen_np = 1;
  int gen_nr = 1;

  int  idle_pct  = 0;
  int  stall_pct = 0;
  int  errors    = 0;
  int  item_cnt  = 0;
  bit  in_fire   = 1'b0;

  function automatic int clamp_count(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // Run the safety test over the predictor stores; queue the grants it owes.
  task automatic predict_safety();
    int     np, nr, cnt, i, j;
    longint work[MaxRes];
    longint need;
    bit     done[MaxProcs];
    int     order[MaxProcs];
    bit     found, fits;
    grant_t g;
    np = clamp_count(int'(procs_reg), MaxProcs);
    nr = clamp_count(int'(res_reg[3:0]), MaxRes);
    for (j = 0; j < MaxRes; j++) work[j] = (j < nr) ? longint'(avail_mdl[j]) : 0;
    for (i = 0; i < MaxProcs; i++) done[i] = 1'b0;
    cnt = 0;
    found = 1'b1;
    while (cnt < np && found) begin
      found = 1'b0;
      for (i = 0; i < np; i++) begin
        if (done[i]) continue;
        fits = 1'b1;
        for (j = 0; j < nr; j++) begin
          // Need is signed: an allocation above the claim makes it negative.
          need = longint'(claim_mdl[i*MaxRes+j]) - longint'(alloc_mdl[i*MaxRes+j]);
          if (need > work[j]) fits = 1'b0;
        end
        if (!fits) continue;
        for (j = 0; j < nr; j++) work[j] += longint'(alloc_mdl[i*MaxRes+j]);
        order[cnt] = i;
        cnt++;
        done[i] = 1'b1;
        found = 1'b1;
      end
    end
    if (cnt < np) begin
      g.safe = 1'b0; g.pid = '0; g.fin = 1'b1;
      owed_grants = {owed_grants, g};
    end else begin
      for (i = 0; i < np; i++) begin
        g.safe = 1'b1;
        g.pid  = order[i][ProcBits-1:0];
        g.fin  = (i == np - 1);
        owed_grants = {owed_grants, g};
      end
    end
  endtask

  // Input side: on an accepted transaction, update stores or predict a check.
  always @(posedge clk) begin
    in_fire = in_valid && !in_stall && !rst;
    if (in_fire) begin
      case (req_type)
        REQ_AVAIL: avail_mdl[res_index] = value;
        REQ_MAX:   claim_mdl[{proc_index, res_index}] = value;
        REQ_ALLOC: alloc_mdl[{proc_index, res_index}] = value;
        default:   predict_safety();
      endcase
    end
  end

  // Driver: advance to the next item once the current one is taken.
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        req_type   <= pending_reqs[0].kind;
        proc_index <= pending_reqs[0].pidx;
        res_index  <= pending_reqs[0].ridx;
        value      <= pending_reqs[0].val;
        void'(pending_reqs.pop_front());
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: compare each grant transaction against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (owed_grants.size() == 0) begin
        $display("%0t: unexpected result is_safe=%0b proc_id=%0d last=%0b",
                 $time, is_safe, proc_id, last);
        errors++;
      end else begin
        if (is_safe !== owed_grants[0].safe) begin
          $display("%0t: is_safe expected %0b actual %0b", $time,
                   owed_grants[0].safe, is_safe);
          errors++;
        end
        if (proc_id !== owed_grants[0].pid) begin
          $display("%0t: proc_id expected %0d actual %0d", $time,
                   owed_grants[0].pid, proc_id);
          errors++;
        end
        if (last !== owed_grants[0].fin) begin
          $display("%0t: last expected %0b actual %0b", $time,
                   owed_grants[0].fin, last);
          errors++;
        end
        void'(owed_grants.pop_front());
      end
    end
  end

  // Hold the write until the block takes it, then drop valid.
  task automatic write_count(logic idx, logic [NpBits-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_NUM_PROCS) procs_reg = data;
    else res_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ValueBits-1:0] pick_value();
    case ($urandom_range(9))
      0:       return ValueBits'($urandom_range(65535));
      1:       return 16'hFFFF;
      default: return ValueBits'($urandom_range(6));
    endcase
  endfunction

  function automatic void push_req(logic [1:0] k, int p, int r, logic [ValueBits-1:0] v);
    req_item_t it;
    it.kind = k;
    it.pidx = p[ProcBits-1:0];
    it.ridx = r[ResBits-1:0];
    it.val  = v;
    pending_reqs = {pending_reqs, it};
    item_cnt++;
    if (k == REQ_AVAIL) avail_loaded[r] = 1'b1;
    else if (k == REQ_MAX) claim_loaded[p*MaxRes+r] = 1'b1;
    else if (k == REQ_ALLOC) alloc_loaded[p*MaxRes+r] = 1'b1;
  endfunction

  // Load every entry the coming check reads that was never loaded.
  function automatic void fill_unloaded();
    int p, r;
    for (r = 0; r < gen_nr; r++) begin
      // Available loads ignore proc_index; give it random content.
      if (!avail_loaded[r]) push_req(REQ_AVAIL, $urandom_range(15), r, pick_value());
      for (p = 0; p < gen_np; p++) begin
        if (!claim_loaded[p*MaxRes+r]) push_req(REQ_MAX, p, r, pick_value());
        if (!alloc_loaded[p*MaxRes+r]) push_req(REQ_ALLOC, p, r, pick_value());
      end
    end
  endfunction

  // Drain: all items accepted, all grants seen, then a short settle.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || owed_grants.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_counts(int np_raw, int nr_raw);
    write_count(CFG_NUM_PROCS, np_raw[NpBits-1:0]);
    write_count(CFG_NUM_RES, nr_raw[NpBits-1:0]);
    gen_np = clamp_count(np_raw & 31, MaxProcs);
    gen_nr = clamp_count(nr_raw & 15, MaxRes);
  endtask

  initial begin
    int ph, c, k, np_raw, nr_raw, nchk;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: one process, one resource; extremes of value and need.
    set_counts(1, 1);
    push_req(REQ_AVAIL, 15, 0, 16'hFFFF);
    push_req(REQ_MAX, 0, 0, 16'hFFFF);
    push_req(REQ_ALLOC, 0, 0, 16'h0000);
    push_req(REQ_CHECK, 0, 0, 16'h0000);              // safe, need equals work
    push_req(REQ_AVAIL, 0, 0, 16'h0000);
    push_req(REQ_CHECK, 15, 7, 16'hFFFF);             // unsafe, huge need
    push_req(REQ_MAX, 0, 0, 16'h0000);
    push_req(REQ_ALLOC, 0, 0, 16'hFFFF);
    push_req(REQ_CHECK, 0, 0, 16'h0000);              // negative need
    drain();

    // Directed: out-of-range counts are clamped (zero and above the maximum).
    set_counts(0, 0);
    push_req(REQ_CHECK, 0, 0, 16'h0000);
    drain();
    set_counts(31, 15);
    fill_unloaded();
    push_req(REQ_CHECK, 0, 0, 16'h0000);
    drain();
    set_counts(17, 16);                               // 16 masks to a zero count, clamped to one resource
    push_req(REQ_CHECK, 0, 0, 16'h0000);
    drain();

    // Random phases: rotate idling modes, mostly small matrices.
    ph = 0;
    while (item_cnt < 470) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 30; stall_pct = 30; end
      endcase
      if ($urandom_range(7) == 0) begin
        np_raw = (ph % 2) ? 16 : $urandom_range(31);
        nr_raw = (ph % 2) ? 8 : $urandom_range(31);
      end else begin
        np_raw = $urandom_range(1, 6);
        nr_raw = $urandom_range(1, 4);
      end
      set_counts(np_raw, nr_raw);
      fill_unloaded();
      nchk = $urandom_range(1, 3);
      for (c = 0; c < nchk; c++) begin
        for (k = $urandom_range(2, 10); k > 0; k--) begin
          if ($urandom_range(4) == 0)
            // Noise: rows and columns anywhere in the stores, also beyond the counts in use.
            push_req(2'($urandom_range(2)), $urandom_range(15), $urandom_range(7),
                     ValueBits'($urandom_range(65535)));
          else
            push_req(2'($urandom_range(2)), $urandom_range(gen_np - 1),
                     $urandom_range(gen_nr - 1), pick_value());
        end
        push_req(REQ_CHECK, $urandom_range(15), $urandom_range(7),
                 ValueBits'($urandom_range(65535)));
      end
      drain();
      ph++;
    end

    idle_pct = 0;
    stall_pct = 0;
    drain();
    if (errors == 0) $display("PASS bankers_safety_check_unit");
    else $display("FAIL bankers_safety_check_unit");
    $finish;
  end

  initial begin
    #100ms;
    $display("FAIL bankers_safety_check_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bsc_pkg.sv
rtl/bsc_datapath.sv
rtl/bsc_ctrl.sv
rtl/bankers_safety_check_unit.sv
tb/testbench.sv
